/* src/dcdd_pkg.sv */
// Package: sizes, state encoding and the byte-to-decimal split for the chunk dedup dictionary.
package dcdd_pkg;

  localparam int DIGITS_PER_CHUNK = 64;
  localparam int DICT_ENTRIES     = 1024;

  localparam int DIGIT_W    = 4;
  localparam int BYTE_W     = 8;
  localparam int POS_W      = $clog2(DIGITS_PER_CHUNK);
  localparam int CHUNK_W    = DIGITS_PER_CHUNK * DIGIT_W;
  localparam int ID_W       = $clog2(DICT_ENTRIES);
  localparam int USED_W     = $clog2(DICT_ENTRIES + 1);
  localparam int CHUNK_ID_W = 10;
  localparam int COUNT_W    = 32;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Three digits per byte: hundreds, tens, units.
  localparam logic [1:0] DIG_HUND  = 2'd0;
  localparam logic [1:0] DIG_UNITS = 2'd2;

  typedef logic [DIGITS_PER_CHUNK-1:0][DIGIT_W-1:0] chunk_t;
  typedef logic [2:0][DIGIT_W-1:0]                  byte_digits_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIGIT,
    S_SRCH,
    S_CNT,
    S_NEW,
    S_EMIT
  } state_t;

  // Split a byte into decimal digits; tens comes from a reciprocal multiply
  // that is exact for every remainder below 100.
  function automatic byte_digits_t split_byte(input logic [BYTE_W-1:0] b);
    logic [1:0]  hund;
    logic [6:0]  rem;
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [6:0]  units;
    byte_digits_t d;
    if (b >= 8'd200) begin
      hund = 2'd2;
      rem  = 7'(b - 8'd200);
    end else if (b >= 8'd100) begin
      hund = 2'd1;
      rem  = 7'(b - 8'd100);
    end else begin
      hund = 2'd0;
      rem  = 7'(b);
    end
    prod  = 15'(rem) * 15'd205;
    tens  = prod[14:11];
    units = rem - 7'(tens) * 7'd10;
    d[0]  = DIGIT_W'(hund);
    d[1]  = tens;
    d[2]  = DIGIT_W'(units);
    return d;
  endfunction

endpackage

/* src/dcdd_stream_if.sv */
// Interfaces: input byte channel and lookup result channel.
interface dcdd_in_if import dcdd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              first_byte;
  logic              last_byte;

  modport source (output valid, output data_byte, output first_byte, output last_byte,
                  input ready);
  modport sink   (input valid, input data_byte, input first_byte, input last_byte,
                  output ready);
endinterface

interface dcdd_out_if import dcdd_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CHUNK_ID_W-1:0] chunk_id;
  logic                  is_new_entry;
  logic [COUNT_W-1:0]    occurrences;
  logic                  dict_full;
  logic                  last_result;

  modport source (output valid, output chunk_id, output is_new_entry, output occurrences,
                  output dict_full, output last_result, input ready);
  modport sink   (input valid, input chunk_id, input is_new_entry, input occurrences,
                  input dict_full, input last_result, output ready);
endinterface

/* src/dcdd_ram.sv */
// Generic single-port RAM with registered read.
module dcdd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic                     we,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

/* src/decimal_chunk_dedup_dictionary_core.sv */
// Top level: decimal chunk builder with sequential dictionary search and counts.
//
//   channel  dir  handshake        payload
//   in_ch    in   valid/ready      data_byte[7:0], first_byte, last_byte
//   out_ch   out  valid/ready      chunk_id[9:0], is_new_entry, occurrences[31:0],
//                                  dict_full, last_result
//
// Sequence: each byte is accepted in S_IDLE, then its three digits are written in S_DIGIT;
//   each chunk lookup reads one key per cycle on the key RAM port, then does a
//   count update or an append, then a result load. A chunk closes about every
//   21 bytes.
// Reset: synchronous, active low; clears the chunk buffer, fill count and
//   result valid. Dictionary RAMs are not cleared: only entries below the fill
//   count are ever compared.
// Stalls: in_ch.ready is high only between items; a result waits in the output
//   register, and only a second result stalls the sequencer until it is taken.
module decimal_chunk_dedup_dictionary_core import dcdd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  dcdd_in_if.sink     in_ch,
  dcdd_out_if.source  out_ch
);

  state_t              state_r, state_nxt;
  byte_digits_t        digs_r, digs_nxt;
  logic [1:0]          k_r, k_nxt;
  logic                last_r, last_nxt;
  logic                fin_r, fin_nxt;
  chunk_t              chunk_r, chunk_nxt;
  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic [USED_W-1:0]   used_r, used_nxt;
  logic [USED_W-1:0]   rd_idx_r, rd_idx_nxt;
  logic                cmp_vld_r, cmp_vld_nxt;
  logic [ID_W-1:0]     cmp_idx_r, cmp_idx_nxt;
  logic [ID_W-1:0]     match_idx_r, match_idx_nxt;

  logic [ID_W-1:0]     res_id_r, res_id_nxt;
  logic                res_new_r, res_new_nxt;
  logic [COUNT_W-1:0]  res_occ_r, res_occ_nxt;
  logic                res_full_r, res_full_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic                  out_load;
  logic [CHUNK_ID_W-1:0] out_id_r;
  logic                  out_new_r;
  logic [COUNT_W-1:0]    out_occ_r;
  logic                  out_full_r;
  logic                  out_last_r;

  logic [ID_W-1:0]     key_addr;
  logic                key_we;
  logic [CHUNK_W-1:0]  key_rdata;
  logic [ID_W-1:0]     cnt_addr;
  logic                cnt_we;
  logic [COUNT_W-1:0]  cnt_wdata;
  logic [COUNT_W-1:0]  cnt_rdata;
  logic                hit;
  logic [COUNT_W-1:0]  occ_inc;

  dcdd_ram #(.WIDTH(CHUNK_W), .DEPTH(DICT_ENTRIES)) u_key_ram (
    .clk   (clk),
    .addr  (key_addr),
    .we    (key_we),
    .wdata (chunk_r),
    .rdata (key_rdata)
  );

  dcdd_ram #(.WIDTH(COUNT_W), .DEPTH(DICT_ENTRIES)) u_cnt_ram (
    .clk   (clk),
    .addr  (cnt_addr),
    .we    (cnt_we),
    .wdata (cnt_wdata),
    .rdata (cnt_rdata)
  );

  // The key read issued last cycle is compared against the held chunk.
  assign hit     = cmp_vld_r && (key_rdata == chunk_r);
  assign occ_inc = (cnt_rdata == COUNT_MAX) ? COUNT_MAX : cnt_rdata + COUNT_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      chunk_r     <= '0;
      pos_r       <= '0;
      used_r      <= '0;
      k_r         <= DIG_HUND;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      chunk_r     <= chunk_nxt;
      pos_r       <= pos_nxt;
      used_r      <= used_nxt;
      k_r         <= k_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    digs_r      <= digs_nxt;
    last_r      <= last_nxt;
    fin_r       <= fin_nxt;
    rd_idx_r    <= rd_idx_nxt;
    cmp_idx_r   <= cmp_idx_nxt;
    match_idx_r <= match_idx_nxt;
    res_id_r    <= res_id_nxt;
    res_new_r   <= res_new_nxt;
    res_occ_r   <= res_occ_nxt;
    res_full_r  <= res_full_nxt;
    if (out_load) begin
      out_id_r   <= CHUNK_ID_W'(res_id_r);
      out_new_r  <= res_new_r;
      out_occ_r  <= res_occ_r;
      out_full_r <= res_full_r;
      out_last_r <= fin_r;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    digs_nxt      = digs_r;
    k_nxt         = k_r;
    last_nxt      = last_r;
    fin_nxt       = fin_r;
    chunk_nxt     = chunk_r;
    pos_nxt       = pos_r;
    used_nxt      = used_r;
    rd_idx_nxt    = rd_idx_r;
    cmp_vld_nxt   = cmp_vld_r;
    cmp_idx_nxt   = cmp_idx_r;
    match_idx_nxt = match_idx_r;
    res_id_nxt    = res_id_r;
    res_new_nxt   = res_new_r;
    res_occ_nxt   = res_occ_r;
    res_full_nxt  = res_full_r;
    key_addr      = rd_idx_r[ID_W-1:0];
    key_we        = 1'b0;
    cnt_addr      = cmp_idx_r;
    cnt_we        = 1'b0;
    cnt_wdata     = '0;
    in_ch.ready   = 1'b0;
    out_load      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ch.ready;

    unique case (state_r)
      S_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          digs_nxt  = split_byte(in_ch.data_byte);
          last_nxt  = in_ch.last_byte;
          k_nxt     = DIG_HUND;
          state_nxt = S_DIGIT;
          // A new file drops the dictionary and any partial chunk.
          if (in_ch.first_byte) begin
            chunk_nxt = '0;
            pos_nxt   = '0;
            used_nxt  = '0;
          end
        end
      end

      S_DIGIT: begin
        chunk_nxt[pos_r] = digs_r[k_r];
        rd_idx_nxt       = '0;
        cmp_vld_nxt      = 1'b0;
        if (pos_r == POS_W'(DIGITS_PER_CHUNK - 1)) begin
          // Chunk complete: look it up now, remaining digits follow after.
          fin_nxt   = last_r && (k_r == DIG_UNITS);
          state_nxt = S_SRCH;
        end else begin
          pos_nxt = pos_r + POS_W'(1);
          if (k_r == DIG_UNITS) begin
            if (last_r) begin
              // Partial chunk on the last byte: look it up zero-padded.
              fin_nxt   = 1'b1;
              state_nxt = S_SRCH;
            end else begin
              state_nxt = S_IDLE;
            end
          end else begin
            k_nxt = k_r + 2'd1;
          end
        end
      end

      S_SRCH: begin
        if (hit) begin
          // Read the count of the matching entry (cnt_addr = cmp_idx_r).
          match_idx_nxt = cmp_idx_r;
          cmp_vld_nxt   = 1'b0;
          state_nxt     = S_CNT;
        end else if (!cmp_vld_r && (rd_idx_r >= used_r)) begin
          state_nxt = S_NEW;
        end else begin
          cmp_vld_nxt = rd_idx_r < used_r;
          cmp_idx_nxt = rd_idx_r[ID_W-1:0];
          if (rd_idx_r < used_r) begin
            rd_idx_nxt = rd_idx_r + USED_W'(1);
          end
        end
      end

      S_CNT: begin
        cnt_addr     = match_idx_r;
        cnt_we       = 1'b1;
        cnt_wdata    = occ_inc;
        res_id_nxt   = match_idx_r;
        res_new_nxt  = 1'b0;
        res_occ_nxt  = occ_inc;
        res_full_nxt = 1'b0;
        state_nxt    = S_EMIT;
      end

      S_NEW: begin
        if (used_r < USED_W'(DICT_ENTRIES)) begin
          key_addr     = used_r[ID_W-1:0];
          key_we       = 1'b1;
          cnt_addr     = used_r[ID_W-1:0];
          cnt_we       = 1'b1;
          cnt_wdata    = COUNT_W'(1);
          res_id_nxt   = used_r[ID_W-1:0];
          res_new_nxt  = 1'b1;
          res_occ_nxt  = COUNT_W'(1);
          res_full_nxt = 1'b0;
          used_nxt     = used_r + USED_W'(1);
        end else begin
          res_id_nxt   = '0;
          res_new_nxt  = 1'b0;
          res_occ_nxt  = '0;
          res_full_nxt = 1'b1;
        end
        state_nxt = S_EMIT;
      end

      S_EMIT: begin
        // Hold until the output register is free, then start a fresh chunk.
        if (!out_valid_r || out_ch.ready) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          chunk_nxt     = '0;
          pos_nxt       = '0;
          if (k_r == DIG_UNITS) begin
            state_nxt = S_IDLE;
          end else begin
            k_nxt     = k_r + 2'd1;
            state_nxt = S_DIGIT;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.chunk_id     = out_id_r;
  assign out_ch.is_new_entry = out_new_r;
  assign out_ch.occurrences  = out_occ_r;
  assign out_ch.dict_full    = out_full_r;
  assign out_ch.last_result  = out_last_r;

`ifndef NO_ASSERTIONS
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= USED_W'(DICT_ENTRIES))
    else $error("fill count beyond dictionary size");

  a_full_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_full_r) |-> (out_id_r == '0 && !out_new_r && out_occ_r == '0))
    else $error("full result carries nonzero fields");

  a_new_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_new_r) |-> (out_occ_r == COUNT_W'(1) && !out_full_r))
    else $error("new entry result without count of one");

  a_first_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && in_ch.first_byte) |=> (used_r == '0 && pos_r == '0))
    else $error("first byte did not clear dictionary");

  a_cmp_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SRCH && cmp_vld_r) |-> (USED_W'(cmp_idx_r) < used_r))
    else $error("compare on an unwritten entry");
`endif

endmodule
